[rtl/core/prs_pkg.sv]
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants for the probe round-trip statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

    // Default geometry
    localparam int SAMPLE_DEPTH_DEF = 1024;
    localparam int DELAY_BITS_DEF   = 20;

    // Fixed field widths and constants
    localparam int CNT_W       = 10;    // probe_count / reply_count
    localparam int LOSS_W      = 7;     // loss_percent
    localparam int MAX_PROBES  = 1000;
    localparam int PERCENT     = 100;
    localparam int SQ_SAT_W    = 64;    // deviation accumulator width is capped here; it saturates at its width
    localparam int PROBE_RESET = 1;

    typedef enum logic [1:0] {
        DIV_AVG,
        DIV_VAR,
        DIV_LOSS
    } div_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG_WAIT,
        ST_SWEEP,
        ST_DRAIN,
        ST_VAR_WAIT,
        ST_SQRT_WAIT,
        ST_LOSS_WAIT,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic     rec;          // record one delay word
        logic     sweep_init;   // clear sample index and square accumulator
        logic     sweep_rd;     // read next stored sample
        logic     div_start;
        div_sel_t div_sel;
        logic     sqrt_start;
        logic     emit;         // load result word and clear the run
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic has_replies;
        logic lim_zero;
        logic sweep_last;
        logic pipe_busy;
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

[rtl/core/prs_ctrl.sv]
// ----------------------------------------------------------------------------
// prs_ctrl
// Sequencer: records replies; on a finish word runs mean, sample sweep,
// variance, square root and loss steps, only loss with no replies, none if the limit is zero too.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          s_cmd,
    output logic               s_ready,
    input  wire prs_pkg::stat_t stat,
    output prs_pkg::cmd_t      cmd
);

    prs_pkg::state_t state_reg;
    prs_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= prs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.div_sel    = prs_pkg::DIV_AVG;
        s_ready        = 1'b0;
        case (state_reg)
            prs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (!s_cmd) begin
                        cmd.rec = 1'b1;
                    end else if (stat.has_replies) begin
                        cmd.div_start  = 1'b1;
                        cmd.div_sel    = prs_pkg::DIV_AVG;
                        cmd.sweep_init = 1'b1;
                        state_next     = prs_pkg::ST_AVG_WAIT;
                    end else if (!stat.lim_zero) begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = prs_pkg::DIV_LOSS;
                        state_next    = prs_pkg::ST_LOSS_WAIT;
                    end else begin
                        state_next = prs_pkg::ST_EMIT;
                    end
                end
            end
            prs_pkg::ST_AVG_WAIT: begin
                if (!stat.div_busy) begin
                    state_next = prs_pkg::ST_SWEEP;
                end
            end
            prs_pkg::ST_SWEEP: begin
                cmd.sweep_rd = 1'b1;
                if (stat.sweep_last) begin
                    state_next = prs_pkg::ST_DRAIN;
                end
            end
            prs_pkg::ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = prs_pkg::DIV_VAR;
                    state_next    = prs_pkg::ST_VAR_WAIT;
                end
            end
            prs_pkg::ST_VAR_WAIT: begin
                if (!stat.div_busy) begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = prs_pkg::ST_SQRT_WAIT;
                end
            end
            prs_pkg::ST_SQRT_WAIT: begin
                // replies present implies a nonzero limit unless the count was lowered to zero during the run
                if (!stat.sqrt_busy) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = prs_pkg::DIV_LOSS;
                    state_next    = prs_pkg::ST_LOSS_WAIT;
                end
            end
            prs_pkg::ST_LOSS_WAIT: begin
                if (!stat.div_busy) begin
                    state_next = prs_pkg::ST_EMIT;
                end
            end
            prs_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = prs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = prs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/prs_dp.sv]
// ----------------------------------------------------------------------------
// prs_dp
// Datapath: sample memory, running sum/min/max, squared-deviation sweep,
// shared restoring divider, bit-pair square root and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_dp #(
    parameter int SAMPLE_DEPTH = prs_pkg::SAMPLE_DEPTH_DEF,
    parameter int DELAY_BITS   = prs_pkg::DELAY_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire prs_pkg::cmd_t               cmd,
    output prs_pkg::stat_t                   stat,
    input  wire logic [DELAY_BITS-1:0]       s_delay_ms,
    input  wire logic                        cfg_valid,
    input  wire logic [prs_pkg::CNT_W-1:0]   cfg_probe_count,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [DELAY_BITS-1:0]            m_rtt_min,
    output logic [DELAY_BITS-1:0]            m_rtt_max,
    output logic [DELAY_BITS-1:0]            m_rtt_avg,
    output logic [DELAY_BITS-1:0]            m_rtt_std,
    output logic [prs_pkg::LOSS_W-1:0]       m_loss_percent,
    output logic [prs_pkg::CNT_W-1:0]        m_reply_count,
    output logic                             m_extra_dropped
);

    localparam int CNT_W   = prs_pkg::CNT_W;
    localparam int LOSS_W  = prs_pkg::LOSS_W;
    localparam int ADDR_W  = $clog2(SAMPLE_DEPTH);
    localparam int SUM_W   = DELAY_BITS + CNT_W;
    localparam int SQ_FULL = 2 * DELAY_BITS + CNT_W;
    localparam int SQ_W    = (SQ_FULL < prs_pkg::SQ_SAT_W) ? SQ_FULL : prs_pkg::SQ_SAT_W;
    // 32-bit probe difference times 100, which is below 2^7
    localparam int LNUM_W  = 32 + LOSS_W;
    localparam int DIV_W   = (SQ_W > LNUM_W) ? SQ_W : LNUM_W;
    localparam int SQ_E    = SQ_W + (SQ_W % 2);
    localparam int ROOT_W  = SQ_E / 2;
    localparam int DCNT_W  = $clog2(DIV_W);
    localparam int RCNT_W  = $clog2(ROOT_W);
    localparam int LIM_CAP = (SAMPLE_DEPTH < prs_pkg::MAX_PROBES) ?
                             SAMPLE_DEPTH : prs_pkg::MAX_PROBES;

    // ---------------- run state ----------------
    logic [CNT_W-1:0]      pc_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [DELAY_BITS-1:0] min_reg;
    logic [DELAY_BITS-1:0] max_reg;
    logic                  ovf_reg;
    logic [CNT_W-1:0]      lim;
    logic                  full;

    always_comb begin
        if (pc_reg > CNT_W'(LIM_CAP)) begin
            lim = CNT_W'(LIM_CAP);
        end else begin
            lim = pc_reg;
        end
    end

    assign full = (n_reg >= lim);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= CNT_W'(prs_pkg::PROBE_RESET);
        end else if (cfg_valid) begin
            pc_reg <= cfg_probe_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.emit) begin
            n_reg   <= '0;
            sum_reg <= '0;
            min_reg <= '1;
            max_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.rec) begin
            if (full) begin
                ovf_reg <= 1'b1;
            end else begin
                n_reg   <= n_reg + 1'b1;
                sum_reg <= sum_reg + SUM_W'(s_delay_ms);
                if (s_delay_ms < min_reg) begin
                    min_reg <= s_delay_ms;
                end
                if (s_delay_ms > max_reg) begin
                    max_reg <= s_delay_ms;
                end
            end
        end
    end

    // ---------------- sample memory ----------------
    logic [DELAY_BITS-1:0] mem [SAMPLE_DEPTH];
    logic [CNT_W-1:0]      idx_reg;
    logic [DELAY_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.rec && !full) begin
            mem[ADDR_W'(n_reg)] <= s_delay_ms;
        end
        if (cmd.sweep_rd) begin
            rd_data_reg <= mem[ADDR_W'(idx_reg)];
        end
    end

    // ---------------- deviation sweep: read, diff, square, accumulate --------
    logic                    p1_valid_reg;
    logic                    p2_valid_reg;
    logic                    p3_valid_reg;
    logic [DELAY_BITS-1:0]   avg_reg;
    logic [DELAY_BITS-1:0]   diff_reg;
    logic [2*DELAY_BITS-1:0] sqr_reg;
    logic [SQ_W-1:0]         sq_acc_reg;
    logic [SQ_W:0]           sq_acc_sum;

    assign sq_acc_sum = {1'b0, sq_acc_reg} + (SQ_W + 1)'(sqr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= cmd.sweep_rd;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sweep_init) begin
            idx_reg    <= '0;
            sq_acc_reg <= '0;
        end else begin
            if (cmd.sweep_rd) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (p3_valid_reg) begin
                // saturate on carry out
                sq_acc_reg <= sq_acc_sum[SQ_W] ? '1 : sq_acc_sum[SQ_W-1:0];
            end
        end
        diff_reg <= (avg_reg >= rd_data_reg) ? (avg_reg - rd_data_reg)
                                             : (rd_data_reg - avg_reg);
        sqr_reg  <= (2 * DELAY_BITS)'(diff_reg) * (2 * DELAY_BITS)'(diff_reg);
    end

    // ---------------- shared restoring divider, one quotient bit a cycle -----
    logic                div_busy_reg;
    prs_pkg::div_sel_t   div_sel_reg;
    logic [DIV_W-1:0]    div_quo_reg;
    logic [CNT_W-1:0]    div_rem_reg;
    logic [CNT_W-1:0]    div_dvs_reg;
    logic [DCNT_W-1:0]   div_cnt_reg;
    logic [LOSS_W-1:0]   loss_reg;
    logic [DIV_W-1:0]    div_dividend;
    logic [CNT_W-1:0]    div_divisor;
    logic [31:0]         loss_left;
    logic [LNUM_W-1:0]   loss_num;
    logic [CNT_W:0]      div_rem_sh;
    logic [CNT_W:0]      div_rem_sub;
    logic                div_ge;
    logic [CNT_W-1:0]    div_rem_next;
    logic [DIV_W-1:0]    div_quo_next;

    // wraps at 32 bits if the count was lowered below the replies of the run
    assign loss_left = 32'(lim) - 32'(n_reg);
    assign loss_num  = LNUM_W'(loss_left) * LNUM_W'(prs_pkg::PERCENT);

    always_comb begin
        case (cmd.div_sel)
            prs_pkg::DIV_AVG: begin
                div_dividend = DIV_W'(sum_reg);
                div_divisor  = n_reg;
            end
            prs_pkg::DIV_VAR: begin
                div_dividend = DIV_W'(sq_acc_reg);
                div_divisor  = n_reg;
            end
            prs_pkg::DIV_LOSS: begin
                div_dividend = DIV_W'(loss_num);
                div_divisor  = lim;
            end
            default: begin
                div_dividend = '0;
                div_divisor  = lim;
            end
        endcase
    end

    assign div_rem_sh   = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_rem_sub  = div_rem_sh - {1'b0, div_dvs_reg};
    assign div_ge       = (div_rem_sh >= {1'b0, div_dvs_reg});
    assign div_rem_next = div_ge ? div_rem_sub[CNT_W-1:0] : div_rem_sh[CNT_W-1:0];
    assign div_quo_next = {div_quo_reg[DIV_W-2:0], div_ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
        end else if (cmd.div_start) begin
            div_busy_reg <= 1'b1;
        end else if (div_busy_reg && div_cnt_reg == '0) begin
            div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            div_sel_reg <= cmd.div_sel;
            div_quo_reg <= div_dividend;
            div_rem_reg <= '0;
            div_dvs_reg <= div_divisor;
            div_cnt_reg <= DCNT_W'(DIV_W - 1);
        end else if (div_busy_reg) begin
            div_quo_reg <= div_quo_next;
            div_rem_reg <= div_rem_next;
            div_cnt_reg <= div_cnt_reg - 1'b1;
            if (div_cnt_reg == '0) begin
                if (div_sel_reg == prs_pkg::DIV_AVG) begin
                    avg_reg <= div_quo_next[DELAY_BITS-1:0];
                end
                if (div_sel_reg == prs_pkg::DIV_LOSS) begin
                    loss_reg <= div_quo_next[LOSS_W-1:0];
                end
            end
        end
    end

    // ---------------- square root, one result bit per cycle ----------------
    logic                  sqrt_busy_reg;
    logic [SQ_E-1:0]       sq_v_reg;
    logic [ROOT_W:0]       sq_rem_reg;
    logic [ROOT_W-1:0]     sq_root_reg;
    logic [RCNT_W-1:0]     sq_cnt_reg;
    logic [DELAY_BITS-1:0] std_reg;
    logic [ROOT_W+2:0]     sq_rem_sh;
    logic [ROOT_W+2:0]     sq_trial;
    logic [ROOT_W+2:0]     sq_rem_sub;
    logic                  sq_ge;
    logic [ROOT_W-1:0]     sq_root_next;

    assign sq_rem_sh    = {sq_rem_reg, sq_v_reg[SQ_E-1 -: 2]};
    assign sq_trial     = {1'b0, sq_root_reg, 2'b01};
    assign sq_rem_sub   = sq_rem_sh - sq_trial;
    assign sq_ge        = (sq_rem_sh >= sq_trial);
    assign sq_root_next = {sq_root_reg[ROOT_W-2:0], sq_ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sqrt_busy_reg <= 1'b0;
        end else if (cmd.sqrt_start) begin
            sqrt_busy_reg <= 1'b1;
        end else if (sqrt_busy_reg && sq_cnt_reg == '0) begin
            sqrt_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_start) begin
            sq_v_reg    <= SQ_E'(div_quo_reg);
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
            sq_cnt_reg  <= RCNT_W'(ROOT_W - 1);
        end else if (sqrt_busy_reg) begin
            sq_v_reg    <= {sq_v_reg[SQ_E-3:0], 2'b00};
            sq_rem_reg  <= sq_ge ? sq_rem_sub[ROOT_W:0] : sq_rem_sh[ROOT_W:0];
            sq_root_reg <= sq_root_next;
            sq_cnt_reg  <= sq_cnt_reg - 1'b1;
            if (sq_cnt_reg == '0) begin
                std_reg <= sq_root_next[DELAY_BITS-1:0];
            end
        end
    end

    // ---------------- result register ----------------
    logic m_valid_reg;
    logic has_replies;

    assign has_replies = (n_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_rtt_min       <= has_replies ? min_reg : '0;
            m_rtt_max       <= has_replies ? max_reg : '0;
            m_rtt_avg       <= has_replies ? avg_reg : '0;
            m_rtt_std       <= has_replies ? std_reg : '0;
            m_loss_percent  <= (lim == '0) ? '0 : loss_reg;
            m_reply_count   <= n_reg;
            m_extra_dropped <= ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // ---------------- status ----------------
    always_comb begin
        stat             = '0;
        stat.has_replies = has_replies;
        stat.lim_zero    = (lim == '0);
        stat.sweep_last  = (idx_reg == n_reg - 1'b1);
        stat.pipe_busy   = p1_valid_reg | p2_valid_reg | p3_valid_reg;
        stat.div_busy    = div_busy_reg;
        stat.sqrt_busy   = sqrt_busy_reg;
        stat.out_free    = !m_valid_reg || m_ready;
    end

    // ---------------- assertions ----------------
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !div_busy_reg && !sqrt_busy_reg)
        else $error("divider started while a division or root is running");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result word overwritten before it was taken");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (n_reg == '0) && !ovf_reg && (sum_reg == '0))
        else $error("run counters not cleared after report");

    a_sweep_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start && (cmd.div_sel == prs_pkg::DIV_VAR) |->
            !p1_valid_reg && !p2_valid_reg && !p3_valid_reg)
        else $error("variance division started before sweep drained");

endmodule

`default_nettype wire

[rtl/core/probe_rtt_statistics.sv]
// ----------------------------------------------------------------------------
// probe_rtt_statistics
// Round-trip delay statistics for one echo probe run.
// ----------------------------------------------------------------------------
// A record word (s_cmd = 0) stores one reply delay, or is dropped once the run
// is full; records may arrive back to back. A finish word (s_cmd = 1) walks
// the stored samples and runs a shared one-bit-per-cycle divider three
// times and a one-bit-per-cycle square root, then loads the result word
// and clears the run; with no replies it runs only the loss division, or
// none when the limit is zero. The divider is W bits wide, the larger of
// 39 and min(2*DELAY_BITS + 10, 64), and the root R bits, half of
// min(2*DELAY_BITS + 10, 64) rounded up (W = 50 and R = 25 at the
// default parameters).
// The result register frees the input side, so records of the next run are
// accepted while a report waits on m_ready. The probe count register is
// written through cfg_valid/cfg_ready and resets to one.
// ----------------------------------------------------------------------------
`default_nettype none

module probe_rtt_statistics #(
    parameter int SAMPLE_DEPTH = prs_pkg::SAMPLE_DEPTH_DEF,
    parameter int DELAY_BITS   = prs_pkg::DELAY_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // configuration
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [prs_pkg::CNT_W-1:0]   cfg_probe_count,
    // input words
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_cmd,
    input  wire logic [DELAY_BITS-1:0]       s_delay_ms,
    // result words
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [DELAY_BITS-1:0]            m_rtt_min,
    output logic [DELAY_BITS-1:0]            m_rtt_max,
    output logic [DELAY_BITS-1:0]            m_rtt_avg,
    output logic [DELAY_BITS-1:0]            m_rtt_std,
    output logic [prs_pkg::LOSS_W-1:0]       m_loss_percent,
    output logic [prs_pkg::CNT_W-1:0]        m_reply_count,
    output logic                             m_extra_dropped
);

    prs_pkg::cmd_t  cmd;
    prs_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    prs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    prs_dp #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .DELAY_BITS   (DELAY_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_delay_ms      (s_delay_ms),
        .cfg_valid       (cfg_valid),
        .cfg_probe_count (cfg_probe_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rtt_min       (m_rtt_min),
        .m_rtt_max       (m_rtt_max),
        .m_rtt_avg       (m_rtt_avg),
        .m_rtt_std       (m_rtt_std),
        .m_loss_percent  (m_loss_percent),
        .m_reply_count   (m_reply_count),
        .m_extra_dropped (m_extra_dropped)
    );

endmodule

`default_nettype wire

[tb/sv/prs_tb_pkg.sv]
// ----------------------------------------------------------------------------
// prs_tb_pkg
// Input word opcodes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package prs_tb_pkg;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_FINISH = 1'b1
    } prs_op_t;

endpackage

[tb/sv/prs_checker.sv]
// ----------------------------------------------------------------------------
// prs_checker
// Watches the config, input and result channels of the round-trip statistics
// block, keeps its own copy of the run state, predicts one report per finish
// word and compares every accepted report field by field, in order.
// ----------------------------------------------------------------------------
module prs_checker
    import prs_pkg::*;
    import prs_tb_pkg::*;
#(
    parameter int DW    = DELAY_BITS_DEF,
    parameter int DEPTH = SAMPLE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_probe_count,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_cmd,
    input  logic [DW-1:0]     s_delay_ms,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [DW-1:0]     m_rtt_min,
    input  logic [DW-1:0]     m_rtt_max,
    input  logic [DW-1:0]     m_rtt_avg,
    input  logic [DW-1:0]     m_rtt_std,
    input  logic [LOSS_W-1:0] m_loss_percent,
    input  logic [CNT_W-1:0]  m_reply_count,
    input  logic              m_extra_dropped,
    output int unsigned       fail_count,
    output int unsigned       pending,
    output int unsigned       reports_seen
);

    typedef struct packed {
        logic [DW-1:0]     lo;
        logic [DW-1:0]     hi;
        logic [DW-1:0]     mean;
        logic [DW-1:0]     dev;
        logic [LOSS_W-1:0] loss;
        logic [CNT_W-1:0]  replies;
        logic              extra;
    } rtt_report_t;

    logic [DW-1:0]    sample_mem [DEPTH];
    int unsigned      reply_total;
    longint unsigned  delay_sum;
    logic [DW-1:0]    run_lo;
    logic [DW-1:0]    run_hi;
    logic             extra_seen;
    logic [CNT_W-1:0] probe_cfg;
    rtt_report_t      report_q [$];
    int unsigned      mismatches;
    int unsigned      checked;

    assign fail_count   = mismatches;
    assign reports_seen = checked;

    function automatic void clear_stats();
        reply_total = 0;
        delay_sum   = 0;
        run_lo      = '1;
        run_hi      = '0;
        extra_seen  = 1'b0;
    endfunction

    task automatic flag(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] report %0d: %s is %0h, predicted %0h",
                 $time, checked, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        rtt_report_t     got;
        rtt_report_t     want;
        int unsigned     lim;
        int unsigned     i;
        int              b;
        int unsigned     left;
        longint unsigned lnum;
        longint unsigned mean;
        longint unsigned diff;
        longint unsigned part;
        longint unsigned sq;
        longint unsigned root;
        longint unsigned trial;

        if (!aresetn) begin
            probe_cfg = CNT_W'(PROBE_RESET);
            clear_stats();
            report_q.delete();
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                probe_cfg = cfg_probe_count;

            if (m_valid && m_ready) begin
                got = {m_rtt_min, m_rtt_max, m_rtt_avg, m_rtt_std,
                       m_loss_percent, m_reply_count, m_extra_dropped};
                if (report_q.size() == 0) begin
                    flag("unpredicted word, reply_count", got.replies, 0);
                end else begin
                    want = report_q.pop_front();
                    if (got.lo !== want.lo)           flag("rtt_min", got.lo, want.lo);
                    if (got.hi !== want.hi)           flag("rtt_max", got.hi, want.hi);
                    if (got.mean !== want.mean)       flag("rtt_avg", got.mean, want.mean);
                    if (got.dev !== want.dev)         flag("rtt_std", got.dev, want.dev);
                    if (got.loss !== want.loss)       flag("loss_percent", got.loss, want.loss);
                    if (got.replies !== want.replies) flag("reply_count", got.replies, want.replies);
                    if (got.extra !== want.extra)     flag("extra_dropped", got.extra, want.extra);
                end
                checked++;
            end

            if (s_valid && s_ready) begin
                // probe counts beyond the supported run size clamp down
                lim = probe_cfg;
                if (lim > MAX_PROBES)
                    lim = MAX_PROBES;
                if (lim > DEPTH)
                    lim = DEPTH;

                if (prs_op_t'(s_cmd) == OP_RECORD) begin
                    if (reply_total >= lim) begin
                        extra_seen = 1'b1;
                    end else begin
                        sample_mem[reply_total % DEPTH] = s_delay_ms;
                        reply_total++;
                        delay_sum += s_delay_ms;
                        if (s_delay_ms < run_lo)
                            run_lo = s_delay_ms;
                        if (s_delay_ms > run_hi)
                            run_hi = s_delay_ms;
                    end
                end else begin
                    want = '0;
                    if (reply_total > 0) begin
                        mean = delay_sum / reply_total;
                        sq   = 0;
                        for (i = 0; i < reply_total; i++) begin
                            diff = (mean >= sample_mem[i]) ? mean - sample_mem[i]
                                                           : sample_mem[i] - mean;
                            part = diff * diff;
                            sq   = (sq > ~64'd0 - part) ? ~64'd0 : sq + part;
                        end
                        sq = sq / reply_total;
                        // floor square root, one result bit at a time from the top
                        root = 0;
                        for (b = 31; b >= 0; b--) begin
                            trial = root | (64'd1 << b);
                            if (trial * trial <= sq)
                                root = trial;
                        end
                        want.lo   = run_lo;
                        want.hi   = run_hi;
                        want.mean = DW'(mean);
                        want.dev  = DW'(root);
                    end
                    if (lim > 0) begin
                        // difference wraps at 32 bits, the product does not
                        left      = lim - reply_total;
                        lnum      = left;
                        want.loss = LOSS_W'((lnum * PERCENT) / lim);
                    end
                    want.replies = CNT_W'(reply_total);
                    want.extra   = extra_seen;
                    report_q.push_back(want);
                    clear_stats();
                end
            end

            pending <= report_q.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the probe round-trip statistics block: directed
// corner runs, one full-size run, a long result-side stall, then random runs
// over many probe-count settings with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import prs_pkg::*;
    import prs_tb_pkg::*;

    localparam int DW            = DELAY_BITS_DEF;
    localparam int ITEM_TARGET   = 1800;
    localparam int QUIET_TAIL    = 250;
    localparam int HOLD_CYCLES   = 900;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 300;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam logic [DW-1:0] DELAY_MAX = '1;

    logic              aclk            = 1'b0;
    logic              aresetn         = 1'b0;
    logic              cfg_valid       = 1'b0;
    logic [CNT_W-1:0]  cfg_probe_count = '0;
    logic              s_valid         = 1'b0;
    logic              s_cmd           = 1'b0;
    logic [DW-1:0]     s_delay_ms      = '0;
    logic              m_ready         = 1'b0;

    logic              cfg_ready;
    logic              s_ready;
    logic              m_valid;
    logic [DW-1:0]     m_rtt_min;
    logic [DW-1:0]     m_rtt_max;
    logic [DW-1:0]     m_rtt_avg;
    logic [DW-1:0]     m_rtt_std;
    logic [LOSS_W-1:0] m_loss_percent;
    logic [CNT_W-1:0]  m_reply_count;
    logic              m_extra_dropped;

    int unsigned       fail_count;
    int unsigned       pending;
    int unsigned       reports_seen;
    int unsigned       words_sent    = 0;
    int unsigned       settings_used = 0;
    bit                quiet         = 1'b0;
    bit                src_bursty    = 1'b1;
    bit                hold_req      = 1'b0;

    probe_rtt_statistics dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_probe_count (cfg_probe_count),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_delay_ms      (s_delay_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rtt_min       (m_rtt_min),
        .m_rtt_max       (m_rtt_max),
        .m_rtt_avg       (m_rtt_avg),
        .m_rtt_std       (m_rtt_std),
        .m_loss_percent  (m_loss_percent),
        .m_reply_count   (m_reply_count),
        .m_extra_dropped (m_extra_dropped)
    );

    prs_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_probe_count (cfg_probe_count),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_delay_ms      (s_delay_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rtt_min       (m_rtt_min),
        .m_rtt_max       (m_rtt_max),
        .m_rtt_avg       (m_rtt_avg),
        .m_rtt_std       (m_rtt_std),
        .m_loss_percent  (m_loss_percent),
        .m_reply_count   (m_reply_count),
        .m_extra_dropped (m_extra_dropped),
        .fail_count      (fail_count),
        .pending         (pending),
        .reports_seen    (reports_seen)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #(2 * LIMIT_CYCLES);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random stall bursts, one long hold-off on request
    always begin : sink
        int          gap;
        int unsigned cyc;
        bit          bursty;
        bit          hold_done;

        @(posedge aclk);
        cyc++;
        if (cyc % 150 == 0)
            bursty = ($urandom_range(0, 2) != 0);
        if (hold_req && !hold_done) begin
            m_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_done = 1'b1;
            m_ready <= 1'b1;
        end else if (!quiet && bursty && $urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(posedge aclk);
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // valid stays up between back-to-back words; it only drops for a gap
    task automatic send_word(input prs_op_t op, input logic [DW-1:0] delay);
        int gap;
        if (!quiet && src_bursty && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= op;
        s_delay_ms <= delay;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        quiet <= (words_sent >= ITEM_TARGET - QUIET_TAIL);
    endtask

    // only written with nothing in flight; records leave no report behind,
    // so the SETTLE_CYCLES wait covers the last one
    task automatic set_probes(input logic [CNT_W-1:0] cnt);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid       <= 1'b1;
        cfg_probe_count <= cnt;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [DW-1:0] pick_delay(input int style, input logic [DW-1:0] base);
        case (style)
            0:       return DW'($urandom);
            1:       return base + DW'($urandom_range(0, 15));
            2:       return base;
            default: return DW'($urandom_range(0, 400));
        endcase
    endfunction

    task automatic play_run(input int unsigned replies);
        int            style;
        logic [DW-1:0] base;
        int unsigned   k;
        style = $urandom_range(0, 3);
        base  = DW'($urandom);
        for (k = 0; k < replies; k++)
            send_word(OP_RECORD, pick_delay(style, base));
        send_word(OP_FINISH, DW'($urandom));
    endtask

    initial begin : stim
        logic [CNT_W-1:0] cnt;
        int unsigned      eff;
        int unsigned      n;
        int unsigned      runs;
        int unsigned      r;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // probe count still at its reset value of one
        send_word(OP_FINISH, DELAY_MAX);
        send_word(OP_RECORD, '0);
        send_word(OP_FINISH, '0);
        send_word(OP_RECORD, DELAY_MAX);
        send_word(OP_RECORD, DW'(5));
        send_word(OP_FINISH, '0);

        // zero probes: everything is dropped, no loss reported
        set_probes('0);
        send_word(OP_RECORD, DW'(20'h55555));
        send_word(OP_RECORD, DW'(20'hAAAAA));
        send_word(OP_FINISH, '0);

        // widest spread of samples
        set_probes(CNT_W'(4));
        send_word(OP_RECORD, '0);
        send_word(OP_RECORD, DELAY_MAX);
        send_word(OP_RECORD, DELAY_MAX);
        send_word(OP_RECORD, '0);
        send_word(OP_FINISH, DELAY_MAX);

        // count above the run limit clamps
        set_probes('1);
        send_word(OP_RECORD, DW'(7));
        send_word(OP_FINISH, '0);

        set_probes(CNT_W'(3));
        send_word(OP_RECORD, DW'(1));
        send_word(OP_RECORD, DW'(2));
        send_word(OP_RECORD, DW'(4));
        send_word(OP_FINISH, '0);

        // one full-size run plus one reply too many
        set_probes('1);
        play_run(MAX_PROBES + 1);

        // result side stops while finish words keep coming
        set_probes(CNT_W'(3));
        hold_req <= 1'b1;
        repeat (6) play_run(2);

        while (words_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       cnt = '0;
                1:       cnt = CNT_W'(1);
                2:       cnt = CNT_W'($urandom_range(MAX_PROBES, 1023));
                3:       cnt = CNT_W'($urandom_range(41, MAX_PROBES - 1));
                default: cnt = CNT_W'($urandom_range(2, 24));
            endcase
            set_probes(cnt);
            eff        = (cnt > MAX_PROBES) ? MAX_PROBES : cnt;
            src_bursty = ($urandom_range(0, 2) != 0);
            runs       = $urandom_range(1, 4);
            for (r = 0; r < runs; r++) begin
                if (eff > 40) begin
                    n = $urandom_range(0, 40);
                end else begin
                    case ($urandom_range(0, 5))
                        0:       n = 0;
                        1:       n = eff;
                        2:       n = eff + $urandom_range(1, 3);
                        default: n = $urandom_range(0, eff);
                    endcase
                end
                play_run(n);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d words under %0d probe-count settings, %0d reports compared",
                 words_sent, settings_used, reports_seen);
        $display("runs: empty, partial, full 1000-reply, over-count, zero-probe, long stall");
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[probe_rtt_statistics.f]
rtl/core/prs_pkg.sv
rtl/core/prs_ctrl.sv
rtl/core/prs_dp.sv
rtl/core/probe_rtt_statistics.sv
tb/sv/prs_tb_pkg.sv
tb/sv/prs_checker.sv
tb/sv/tb_top.sv
